// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked on clk_i and switched off while rst_ni is low.
`define BMPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check clocked on clk_i that also holds during reset.
`define BMPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/bmpc_pkg.sv =====
`timescale 1ns / 1ps

package bmpc_pkg;

  localparam int STORE_BITS = 4096;
  localparam int CHUNK_BITS = 8;
  localparam int CFG_W      = 13;
  localparam int COUNT_W    = 13;
  localparam int ELEM_W     = 12;
  localparam int CIDX_W     = 9;

  // Input tdata: element_index, bit_value, chunk_index, source_chunk (30 bits, padded to 32).
  localparam int S_TDATA_W  = 32;
  // Output tdata: bit_state, chunk_result, set_count (22 bits, padded to 24).
  localparam int M_TDATA_W  = 24;

  typedef enum logic [2:0] {
    REQ_WRITE_BIT  = 3'd0,
    REQ_TEST_BIT   = 3'd1,
    REQ_COPY       = 3'd2,
    REQ_AND        = 3'd3,
    REQ_OR         = 3'd4,
    REQ_AND_NOT    = 3'd5,
    REQ_NEGATE     = 3'd6
  } req_e;

  localparam logic [2:0] NibbleOnes [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  function automatic logic [3:0] ones8(logic [CHUNK_BITS-1:0] v);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = {1'b0, NibbleOnes[v[7:4]]};
    lo = {1'b0, NibbleOnes[v[3:0]]};
    return hi + lo;
  endfunction

endpackage

// ===== sv/bitmap_set_with_population_count_unit.sv =====
// An accepted request is held in the stage 1 registers, then moves to the result register when the output can advance.
// Throughput: one request per cycle while the output is not stalled; a chunk read issued at acceptance and a
// forwarding path from the chunk write of the previous request keep the pipe full.
// Reset: rst_ni clears control state and the set count; the chunk memory is then
// cleared one chunk per cycle, all (StoreBits+7)/8 chunks (512 by default), with no request
// accepted meanwhile. Configuration writes are taken at all times.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bitmap_set_with_population_count_unit
  import bmpc_pkg::*;
#(
  parameter int StoreBits = STORE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [CFG_W-1:0]     cfg_wr_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // element_index[11:0], bit_value[12], chunk_index[21:13], source_chunk[29:22]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // req_type[2:0]
  input  logic [2:0]           s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // bit_state[0], chunk_result[8:1], set_count[21:9]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // error[0]
  output logic                 m_axis_tuser_o
);

  localparam int Depth    = (StoreBits + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SizeBits = $clog2(StoreBits + 1);
  localparam int SizeW    = (SizeBits > CFG_W) ? SizeBits : CFG_W;

  // Configuration and effective size.
  logic [CFG_W-1:0] bits_in_use_q;
  logic [SizeW-1:0] cfg_ext;
  logic [SizeW-1:0] size_eff;
  logic [SizeW-1:0] size_chunks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= CFG_W'(4096);
    end else if (cfg_wr_en_i) begin
      bits_in_use_q <= cfg_wr_data_i;
    end
  end

  assign cfg_ext     = SizeW'(bits_in_use_q);
  assign size_eff    = (cfg_ext > SizeW'(StoreBits)) ? SizeW'(StoreBits) : cfg_ext;
  assign size_chunks = size_eff >> 3;

  // Clearing pass after reset.
  logic             clearing_q;
  logic [AddrW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
    end
  end

  // Input decode.
  logic [2:0]            in_type;
  logic [ELEM_W-1:0]     in_elem;
  logic                  in_bval;
  logic [CIDX_W-1:0]     in_cidx;
  logic [CHUNK_BITS-1:0] in_src;
  logic                  in_is_bit;
  logic [CIDX_W-1:0]     in_chunk;
  logic [AddrW-1:0]      rd_addr;
  logic                  chunk_full;
  logic                  chunk_part;
  logic                  in_err;
  logic [CHUNK_BITS-1:0] in_mask;

  assign in_type   = s_axis_tuser_i;
  assign in_elem   = s_axis_tdata_i[11:0];
  assign in_bval   = s_axis_tdata_i[12];
  assign in_cidx   = s_axis_tdata_i[21:13];
  assign in_src    = s_axis_tdata_i[29:22];
  assign in_is_bit = (in_type == REQ_WRITE_BIT) || (in_type == REQ_TEST_BIT);
  assign in_chunk  = in_is_bit ? in_elem[ELEM_W-1:3] : in_cidx;
  assign rd_addr   = AddrW'(in_chunk);

  // A chunk is whole when it lies below the last partial chunk of the size.
  assign chunk_full = SizeW'(in_cidx) < size_chunks;
  assign chunk_part = (SizeW'(in_cidx) == size_chunks) && (size_eff[2:0] != 3'd0);
  assign in_mask    = chunk_full ? 8'hFF : ~(8'hFF << size_eff[2:0]);

  always_comb begin
    unique case (in_type)
      REQ_WRITE_BIT, REQ_TEST_BIT: begin
        in_err = !(SizeW'(in_elem) < size_eff);
      end
      REQ_COPY, REQ_AND, REQ_OR, REQ_AND_NOT, REQ_NEGATE: begin
        in_err = !(chunk_full || chunk_part);
      end
      default: begin
        in_err = 1'b1;
      end
    endcase
  end

  // Stage 1 registers.
  logic                  s1_valid_q;
  logic [2:0]            s1_type_q;
  logic [2:0]            s1_off_q;
  logic                  s1_bval_q;
  logic [CHUNK_BITS-1:0] s1_src_q;
  logic [CHUNK_BITS-1:0] s1_mask_q;
  logic [AddrW-1:0]      s1_addr_q;
  logic                  s1_err_q;
  logic                  s1_fwd_q;
  logic [CHUNK_BITS-1:0] s1_fwd_data_q;
  logic [CHUNK_BITS-1:0] rd_data_q;

  logic                  s1_adv;
  logic                  in_accept;
  logic                  s1_writes;
  logic [CHUNK_BITS-1:0] old_chunk;
  logic [CHUNK_BITS-1:0] new_chunk;
  logic [CHUNK_BITS-1:0] bit_chunk;
  logic                  s1_bit_out;

  logic                  m_valid_q;
  logic [M_TDATA_W-1:0]  m_data_q;
  logic                  m_err_q;
  logic [COUNT_W-1:0]    pop_q;
  logic [COUNT_W-1:0]    pop_d;

  assign s1_adv          = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !clearing_q && (!s1_valid_q || s1_adv);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv || !s1_valid_q) begin
      s1_valid_q <= in_accept;
    end
  end

  // The previous request writes its chunk at the same edge this one reads it,
  // so the written value is carried along and used instead of the read data.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_type_q     <= in_type;
      s1_off_q      <= in_elem[2:0];
      s1_bval_q     <= in_bval;
      s1_src_q      <= in_src;
      s1_mask_q     <= in_mask;
      s1_addr_q     <= rd_addr;
      s1_err_q      <= in_err;
      s1_fwd_q      <= s1_writes && (s1_addr_q == rd_addr);
      s1_fwd_data_q <= new_chunk;
    end
  end

  assign old_chunk = s1_fwd_q ? s1_fwd_data_q : rd_data_q;

  always_comb begin
    bit_chunk           = old_chunk;
    bit_chunk[s1_off_q] = s1_bval_q;
  end

  always_comb begin
    unique case (s1_type_q)
      REQ_WRITE_BIT: new_chunk = bit_chunk;
      REQ_COPY:      new_chunk = s1_src_q & s1_mask_q;
      REQ_AND:       new_chunk = old_chunk & s1_src_q & s1_mask_q;
      REQ_OR:        new_chunk = (old_chunk | s1_src_q) & s1_mask_q;
      REQ_AND_NOT:   new_chunk = old_chunk & ~s1_src_q & s1_mask_q;
      REQ_NEGATE:    new_chunk = ~old_chunk & s1_mask_q;
      default:       new_chunk = old_chunk;
    endcase
  end

  assign s1_writes  = s1_valid_q && s1_adv && !s1_err_q && (s1_type_q != REQ_TEST_BIT);
  assign s1_bit_out = new_chunk[s1_off_q];
  assign pop_d      = s1_writes ? (pop_q + COUNT_W'(ones8(new_chunk))
                                   - COUNT_W'(ones8(old_chunk))) : pop_q;

  // Chunk memory.
  logic [CHUNK_BITS-1:0] mem [Depth];
  logic                  mem_we;
  logic [AddrW-1:0]      mem_wa;
  logic [CHUNK_BITS-1:0] mem_wd;

  assign mem_we = clearing_q || s1_writes;
  assign mem_wa = clearing_q ? clr_addr_q : s1_addr_q;
  assign mem_wd = clearing_q ? '0 : new_chunk;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_accept) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Population count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      pop_q <= pop_d;
      if (s1_adv) begin
        m_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      m_err_q <= s1_err_q;
      if (s1_err_q) begin
        m_data_q <= {2'b00, pop_d, 8'h00, 1'b0};
      end else if ((s1_type_q == REQ_WRITE_BIT) || (s1_type_q == REQ_TEST_BIT)) begin
        m_data_q <= {2'b00, pop_d, new_chunk, s1_bit_out};
      end else begin
        m_data_q <= {2'b00, pop_d, new_chunk, 1'b0};
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_err_q;

  `BMPC_ASSERT_ALWAYS(a_no_accept_while_clearing, clearing_q |-> !s_axis_tready_o,
                      "request accepted during the memory clearing pass")
  `BMPC_ASSERT(a_no_write_on_error, (s1_writes && !clearing_q) |-> !s1_err_q,
               "rejected request wrote the chunk memory")
  `BMPC_ASSERT(a_stage1_holds, (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_addr_q)),
               "stalled request left stage 1")
  `BMPC_ASSERT(a_error_result_clear,
               (m_valid_q && m_err_q) |-> (m_data_q[8:0] == 9'd0),
               "rejected request returned chunk or bit data")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bmpc_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int RANDOM_PER_PHASE = 135;
  localparam int RUN_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  // Receiver stall modes.
  localparam int READY_STEADY = 0;
  localparam int READY_COIN = 1;
  localparam int READY_SPARSE = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] elem;
    logic        bval;
    logic [8:0]  cidx;
    logic [7:0]  src;
  } bitmap_req_t;

  typedef struct packed {
    logic              bit_state;
    logic [7:0]        chunk;
    logic [COUNT_W-1:0] count;
    logic              error;
  } bitmap_rsp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_wr_en_i = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [2:0]           s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;

  bitmap_set_with_population_count_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Shadow copy of the bitmap, its set count and the size register.
  logic [7:0]         shadow_chunks [STORE_BITS/CHUNK_BITS];
  logic [COUNT_W-1:0] shadow_count = '0;
  logic [CFG_W-1:0]   model_size = CFG_W'(STORE_BITS);

  bitmap_req_t pending_requests [$];
  bitmap_rsp_t expected_results [$];
  int requests_in_flight = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  initial begin
    foreach (shadow_chunks[i]) shadow_chunks[i] = 8'h00;
  end

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned usable_bits();
    return (model_size > STORE_BITS) ? STORE_BITS : model_size;
  endfunction

  function automatic bitmap_rsp_t predict_bitmap_update(bitmap_req_t r);
    bitmap_rsp_t rsp;
    int unsigned size_eff;
    int unsigned nchunks;
    int unsigned left;
    logic [7:0] before_v;
    logic [7:0] after_v;
    logic [7:0] keep_mask;
    rsp = '0;
    size_eff = usable_bits();
    nchunks = (size_eff + CHUNK_BITS - 1) / CHUNK_BITS;
    if (r.kind == REQ_WRITE_BIT || r.kind == REQ_TEST_BIT) begin
      if (r.elem >= size_eff) begin
        rsp.error = 1'b1;
      end else begin
        before_v = shadow_chunks[r.elem / CHUNK_BITS];
        after_v = before_v;
        if (r.kind == REQ_WRITE_BIT) begin
          after_v[r.elem[2:0]] = r.bval;
          shadow_chunks[r.elem / CHUNK_BITS] = after_v;
          shadow_count = COUNT_W'(shadow_count + $countones(after_v) - $countones(before_v));
        end
        rsp.bit_state = after_v[r.elem[2:0]];
        rsp.chunk = after_v;
      end
    end else if (r.kind == REQ_UNUSED || r.cidx >= nchunks) begin
      rsp.error = 1'b1;
    end else begin
      // Bits past the configured size in the last chunk are always cleared.
      left = size_eff - r.cidx * CHUNK_BITS;
      keep_mask = (left >= CHUNK_BITS) ? 8'hFF : 8'((1 << left) - 1);
      before_v = shadow_chunks[r.cidx];
      case (r.kind)
        REQ_COPY:    after_v = r.src;
        REQ_AND:     after_v = before_v & r.src;
        REQ_OR:      after_v = before_v | r.src;
        REQ_AND_NOT: after_v = before_v & ~r.src;
        default:     after_v = ~before_v;
      endcase
      after_v = after_v & keep_mask;
      shadow_chunks[r.cidx] = after_v;
      shadow_count = COUNT_W'(shadow_count + $countones(after_v) - $countones(before_v));
      rsp.chunk = after_v;
    end
    rsp.count = shadow_count;
    return rsp;
  endfunction

  // Mostly in-range indices, often packed into a few low chunks so that bits get
  // revisited; the rest take any value the fields allow.
  function automatic bitmap_req_t random_request();
    bitmap_req_t r;
    int unsigned size_eff;
    int unsigned nchunks;
    int unsigned lim;
    size_eff = usable_bits();
    nchunks = (size_eff + CHUNK_BITS - 1) / CHUNK_BITS;
    r.kind = ($urandom_range(0, 49) == 0) ? REQ_UNUSED : 3'($urandom_range(0, 6));
    r.elem = 12'($urandom_range(0, 4095));
    r.bval = 1'($urandom_range(0, 1));
    r.cidx = 9'($urandom_range(0, 511));
    r.src = 8'($urandom_range(0, 255));
    if (size_eff != 0 && $urandom_range(0, 9) < 8) begin
      lim = $urandom_range(0, 1) ? size_eff : ((size_eff < 48) ? size_eff : 48);
      r.elem = 12'($urandom_range(0, lim - 1));
      lim = $urandom_range(0, 1) ? nchunks : ((nchunks < 6) ? nchunks : 6);
      r.cidx = 9'($urandom_range(0, lim - 1));
    end
    return r;
  endfunction

  task automatic queue_request(logic [2:0] kind, logic [11:0] elem, logic bval,
                               logic [8:0] cidx, logic [7:0] src);
    pending_requests.push_back('{kind, elem, bval, cidx, src});
    requests_in_flight++;
  endtask

  task automatic wait_for_idle();
    while (requests_in_flight != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_size(logic [CFG_W-1:0] value);
    wait_for_idle();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    model_size = value;
  endtask

  task automatic check_field(string label, logic [12:0] want, logic [12:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin : drive_requests
    bitmap_req_t driven_req;
    int burst_left;
    int gap_left;
    logic next_valid;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_results.push_back(predict_bitmap_update(driven_req));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0) begin
          driven_req = pending_requests.pop_front();
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        s_axis_tvalid_i <= next_valid;
        s_axis_tdata_i <= {2'b00, driven_req.src, driven_req.cidx, driven_req.bval,
                           driven_req.elem};
        s_axis_tuser_i <= driven_req.kind;
      end
    end
  end

  // Result monitor with its own stall pattern on tready.
  always @(posedge clk_i) begin : watch_results
    bitmap_rsp_t want;
    int stall_mode;
    int stall_left;
    int stall_tick;
    logic next_ready;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = expected_results.pop_front();
        check_field("bit_state", 13'(want.bit_state), 13'(m_axis_tdata_o[0]));
        check_field("chunk_result", 13'(want.chunk), 13'(m_axis_tdata_o[8:1]));
        check_field("set_count", want.count, m_axis_tdata_o[21:9]);
        check_field("error", 13'(want.error), 13'(m_axis_tuser_o));
        requests_in_flight--;
      end
    end
    if (stall_left <= 0) begin
      stall_mode = $urandom_range(READY_STEADY, READY_SPARSE);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      READY_STEADY: next_ready = 1'b1;
      READY_COIN:   next_ready = 1'($urandom_range(0, 1));
      default:      next_ready = (stall_tick % 6 == 0);
    endcase
    m_axis_tready_i <= next_ready;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_sizes [8];
    logic [CFG_W-1:0] size_value;
    bitmap_req_t r;
    // A zero entry stands for a size picked at random.
    phase_sizes = '{13'd8191, 13'd1, 13'd9, 13'd4095, 13'd0, 13'd4096, 13'd8, 13'd0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full size after reset: edge bits, every chunk operation, unused request type.
    queue_request(REQ_WRITE_BIT, 12'd0, 1'b1, 9'd0, 8'h00);
    queue_request(REQ_WRITE_BIT, 12'd4095, 1'b1, 9'd511, 8'hFF);
    queue_request(REQ_TEST_BIT, 12'd4095, 1'b0, 9'd0, 8'h00);
    queue_request(REQ_WRITE_BIT, 12'd4095, 1'b0, 9'd0, 8'h00);
    queue_request(REQ_COPY, 12'hFFF, 1'b1, 9'd511, 8'hFF);
    queue_request(REQ_AND, 12'd0, 1'b0, 9'd511, 8'h0F);
    queue_request(REQ_OR, 12'd0, 1'b0, 9'd0, 8'hAA);
    queue_request(REQ_AND_NOT, 12'd0, 1'b0, 9'd0, 8'h0F);
    queue_request(REQ_NEGATE, 12'd0, 1'b0, 9'd0, 8'h00);
    queue_request(REQ_TEST_BIT, 12'd7, 1'b0, 9'd0, 8'h00);
    queue_request(REQ_UNUSED, 12'd0, 1'b0, 9'd0, 8'h00);

    // Partial last chunk: negate and copy must not touch the padding bits.
    write_size(13'd13);
    queue_request(REQ_NEGATE, 12'd0, 1'b0, 9'd1, 8'h00);
    queue_request(REQ_COPY, 12'd0, 1'b0, 9'd1, 8'hFF);
    queue_request(REQ_WRITE_BIT, 12'd13, 1'b1, 9'd0, 8'h00);
    queue_request(REQ_WRITE_BIT, 12'd12, 1'b0, 9'd0, 8'h00);
    queue_request(REQ_TEST_BIT, 12'd12, 1'b0, 9'd0, 8'h00);
    queue_request(REQ_AND, 12'd0, 1'b0, 9'd2, 8'hFF);
    queue_request(REQ_TEST_BIT, 12'd4095, 1'b1, 9'd511, 8'hFF);

    // With no valid bits every request is rejected.
    write_size(13'd0);
    queue_request(REQ_TEST_BIT, 12'd0, 1'b0, 9'd0, 8'h00);
    queue_request(REQ_COPY, 12'd0, 1'b0, 9'd0, 8'hFF);
    queue_request(REQ_WRITE_BIT, 12'd0, 1'b1, 9'd0, 8'h00);
    queue_request(REQ_NEGATE, 12'd0, 1'b0, 9'd0, 8'h00);

    foreach (phase_sizes[p]) begin
      size_value = (phase_sizes[p] == 0) ? CFG_W'($urandom_range(2, STORE_BITS)) : phase_sizes[p];
      write_size(size_value);
      repeat (RANDOM_PER_PHASE) begin
        r = random_request();
        queue_request(r.kind, r.elem, r.bval, r.cidx, r.src);
      end
    end

    wait_for_idle();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
